/* hdl/hse_pkg.sv */
package hse_pkg;

	// Data width of one stored value and the default store depth.
	localparam int VALUE_W      = 32;
	localparam int CAPACITY_DEF = 32;

	// Step counter of the control program.
	typedef logic [4:0] pc_t;

	localparam pc_t PC_LOAD  = 5'd0;
	localparam pc_t PC_BINIT = 5'd1;
	localparam pc_t PC_BCHK  = 5'd2;
	localparam pc_t PC_S0    = 5'd3;
	localparam pc_t PC_S1    = 5'd4;
	localparam pc_t PC_S2    = 5'd5;
	localparam pc_t PC_S3    = 5'd6;
	localparam pc_t PC_S4    = 5'd7;
	localparam pc_t PC_S5    = 5'd8;
	localparam pc_t PC_DINIT = 5'd9;
	localparam pc_t PC_D1    = 5'd10;
	localparam pc_t PC_D2    = 5'd11;
	localparam pc_t PC_X0    = 5'd12;
	localparam pc_t PC_X1    = 5'd13;
	localparam pc_t PC_X2    = 5'd14;
	localparam pc_t PC_X3    = 5'd15;
	localparam pc_t PC_PINIT = 5'd16;
	localparam pc_t PC_P1    = 5'd17;
	localparam pc_t PC_P2    = 5'd18;
	localparam pc_t PC_FIN   = 5'd19;

	// Datapath operation of one step.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_BINIT,
		OP_BSTEP,
		OP_S1,
		OP_S2,
		OP_S3,
		OP_S4,
		OP_S5,
		OP_ICLR,
		OP_EMIT0,
		OP_EMIT1,
		OP_X1,
		OP_X2,
		OP_X3,
		OP_FIN
	} op_t;

	// Address that the store is read at in this step.
	typedef enum logic [2:0] {
		RA_ZERO,
		RA_POS,
		RA_LEFT,
		RA_RIGHT,
		RA_I,
		RA_LENM1
	} rsel_t;

	// Jump condition of one step.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_LAST,
		C_I_ZERO,
		C_NO_LEFT,
		C_NO_RIGHT,
		C_TOP_POS,
		C_I_EQ_N,
		C_LEN_ZERO
	} cond_t;

	// One control word of the program.
	typedef struct packed {
		op_t   op;
		rsel_t rd;
		cond_t cond;
		pc_t   target;
		logic  use_ret;
		logic  ret_set;
		logic  ret_val;
	} ctrl_t;

	// Status the datapath reports back to the sequencer.
	typedef struct packed {
		logic last_acc;
		logic i_zero;
		logic no_left;
		logic no_right;
		logic top_pos;
		logic i_eq_n;
		logic len_zero;
		logic stall;
	} status_t;

	function automatic ctrl_t cw(op_t op, rsel_t rd, cond_t cond, pc_t target,
			logic use_ret, logic ret_set, logic ret_val);
		ctrl_t w;
		w.op      = op;
		w.rd      = rd;
		w.cond    = cond;
		w.target  = target;
		w.use_ret = use_ret;
		w.ret_set = ret_set;
		w.ret_val = ret_val;
		return w;
	endfunction

	// The control program. The sift routine (S0 to S5) returns to the build
	// loop or to the extract loop, as the return bit says.
	function automatic ctrl_t rom(pc_t pc);
		ctrl_t w;
		unique case (pc)
			PC_LOAD:  w = cw(OP_LOAD,  RA_ZERO,  C_NOT_LAST, PC_LOAD,  1'b0, 1'b0, 1'b0);
			PC_BINIT: w = cw(OP_BINIT, RA_ZERO,  C_NEVER,    PC_LOAD,  1'b0, 1'b0, 1'b0);
			PC_BCHK:  w = cw(OP_BSTEP, RA_ZERO,  C_I_ZERO,   PC_DINIT, 1'b0, 1'b1, 1'b0);
			PC_S0:    w = cw(OP_NOP,   RA_POS,   C_NEVER,    PC_LOAD,  1'b0, 1'b0, 1'b0);
			PC_S1:    w = cw(OP_S1,    RA_LEFT,  C_NO_LEFT,  PC_LOAD,  1'b1, 1'b0, 1'b0);
			PC_S2:    w = cw(OP_S2,    RA_RIGHT, C_NO_RIGHT, PC_S4,    1'b0, 1'b0, 1'b0);
			PC_S3:    w = cw(OP_S3,    RA_ZERO,  C_NEVER,    PC_LOAD,  1'b0, 1'b0, 1'b0);
			PC_S4:    w = cw(OP_S4,    RA_ZERO,  C_TOP_POS,  PC_LOAD,  1'b1, 1'b0, 1'b0);
			PC_S5:    w = cw(OP_S5,    RA_ZERO,  C_ALWAYS,   PC_S0,    1'b0, 1'b0, 1'b0);
			PC_DINIT: w = cw(OP_ICLR,  RA_ZERO,  C_NEVER,    PC_LOAD,  1'b0, 1'b0, 1'b0);
			PC_D1:    w = cw(OP_NOP,   RA_I,     C_I_EQ_N,   PC_X0,    1'b0, 1'b0, 1'b0);
			PC_D2:    w = cw(OP_EMIT0, RA_I,     C_ALWAYS,   PC_D1,    1'b0, 1'b0, 1'b0);
			PC_X0:    w = cw(OP_NOP,   RA_ZERO,  C_LEN_ZERO, PC_PINIT, 1'b0, 1'b0, 1'b0);
			PC_X1:    w = cw(OP_X1,    RA_LENM1, C_NEVER,    PC_LOAD,  1'b0, 1'b0, 1'b0);
			PC_X2:    w = cw(OP_X2,    RA_ZERO,  C_NEVER,    PC_LOAD,  1'b0, 1'b0, 1'b0);
			PC_X3:    w = cw(OP_X3,    RA_ZERO,  C_ALWAYS,   PC_S0,    1'b0, 1'b1, 1'b1);
			PC_PINIT: w = cw(OP_ICLR,  RA_ZERO,  C_NEVER,    PC_LOAD,  1'b0, 1'b0, 1'b0);
			PC_P1:    w = cw(OP_NOP,   RA_I,     C_I_EQ_N,   PC_FIN,   1'b0, 1'b0, 1'b0);
			PC_P2:    w = cw(OP_EMIT1, RA_I,     C_ALWAYS,   PC_P1,    1'b0, 1'b0, 1'b0);
			PC_FIN:   w = cw(OP_FIN,   RA_ZERO,  C_ALWAYS,   PC_LOAD,  1'b0, 1'b0, 1'b0);
			default:  w = cw(OP_NOP,   RA_ZERO,  C_ALWAYS,   PC_LOAD,  1'b0, 1'b0, 1'b0);
		endcase
		return w;
	endfunction

endpackage

/* hdl/hse_ram.sv */
module hse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/hse_seq.sv */
module hse_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  hse_pkg::status_t status,
	output hse_pkg::ctrl_t   ctrl
);
	import hse_pkg::*;

	pc_t  pc_q;
	logic ret_q;
	logic taken;
	pc_t  pc_next;

	// Control word of the current step.
	assign ctrl = rom(pc_q);

	// Evaluate the jump condition.
	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:    taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_NOT_LAST: taken = !status.last_acc;
			C_I_ZERO:   taken = status.i_zero;
			C_NO_LEFT:  taken = status.no_left;
			C_NO_RIGHT: taken = status.no_right;
			C_TOP_POS:  taken = status.top_pos;
			C_I_EQ_N:   taken = status.i_eq_n;
			C_LEN_ZERO: taken = status.len_zero;
			default:    taken = 1'b0;
		endcase
	end

	// Next step: hold on a stall, jump target, return point of the sift routine, or fall through.
	always_comb begin
		priority if (status.stall) begin
			pc_next = pc_q;
		end else if (taken && ctrl.use_ret) begin
			pc_next = ret_q ? PC_X0 : PC_BCHK;
		end else if (taken) begin
			pc_next = ctrl.target;
		end else begin
			pc_next = pc_q + pc_t'(1);
		end
	end

	// Step counter and return bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= PC_LOAD;
			ret_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (ctrl.ret_set && !status.stall) begin
				ret_q <= ctrl.ret_val;
			end
		end
	end

endmodule

/* hdl/hse_dp.sv */
module hse_dp #(
	parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  hse_pkg::ctrl_t                     ctrl,
	output hse_pkg::status_t                   status,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic signed [hse_pkg::VALUE_W-1:0] s_tdata,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic signed [hse_pkg::VALUE_W-1:0] m_tdata,
	output logic                               m_tlast,
	output logic [1:0]                         m_tuser
);
	import hse_pkg::*;

	localparam int IDXW = $clog2(CAPACITY);
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int XW   = IDXW + 2;

	logic [CNTW-1:0]           count_q;
	logic                      drop_q;
	logic [CNTW-1:0]           len_q;
	logic [CNTW-1:0]           i_q;
	logic [IDXW-1:0]           pos_q;
	logic [IDXW-1:0]           top_q;
	logic signed [VALUE_W-1:0] cur_q;
	logic signed [VALUE_W-1:0] topv_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_phase_q;
	logic                      out_final_q;
	logic                      out_ovf_q;

	logic                      acc;
	logic                      emit;
	logic                      stall;
	logic                      has_room;
	logic [XW-1:0]             left;
	logic [XW-1:0]             right;
	logic [CNTW-1:0]           lenm1;
	logic [CNTW-1:0]           im1;
	logic [CNTW-1:0]           ip1;
	logic                      we;
	logic [IDXW-1:0]           waddr;
	logic signed [VALUE_W-1:0] wdata;
	logic [IDXW-1:0]           raddr;
	logic signed [VALUE_W-1:0] rdata;

	// Input handshake and the emit stall on a full output register.
	assign s_tready = (ctrl.op == OP_LOAD);
	assign acc      = s_tvalid && s_tready;
	assign emit     = (ctrl.op == OP_EMIT0) || (ctrl.op == OP_EMIT1);
	assign stall    = emit && out_valid_q && !m_tready;
	assign has_room = (count_q < CNTW'(CAPACITY));

	// Child positions and counter neighbors.
	assign left  = {1'b0, pos_q, 1'b1};
	assign right = left + XW'(1);
	assign lenm1 = len_q - CNTW'(1);
	assign im1   = i_q - CNTW'(1);
	assign ip1   = i_q + CNTW'(1);

	// Status toward the sequencer.
	always_comb begin
		status.last_acc = acc && s_tlast;
		status.i_zero   = (i_q == '0);
		status.no_left  = (left >= XW'(len_q));
		status.no_right = (right >= XW'(len_q));
		status.top_pos  = (top_q == pos_q);
		status.i_eq_n   = (i_q == count_q);
		status.len_zero = (len_q == '0);
		status.stall    = stall;
	end

	// Store read address.
	always_comb begin
		unique case (ctrl.rd)
			RA_ZERO:  raddr = '0;
			RA_POS:   raddr = pos_q;
			RA_LEFT:  raddr = left[IDXW-1:0];
			RA_RIGHT: raddr = right[IDXW-1:0];
			RA_I:     raddr = i_q[IDXW-1:0];
			RA_LENM1: raddr = lenm1[IDXW-1:0];
			default:  raddr = '0;
		endcase
	end

	// Store write port.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = cur_q;
		unique case (ctrl.op)
			OP_LOAD: begin
				we    = acc && has_room;
				waddr = count_q[IDXW-1:0];
				wdata = s_tdata;
			end
			OP_S4: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = topv_q;
			end
			OP_S5: begin
				we    = 1'b1;
				waddr = top_q;
				wdata = cur_q;
			end
			OP_X2: begin
				we    = 1'b1;
				waddr = '0;
				wdata = rdata;
			end
			OP_X3: begin
				we    = 1'b1;
				waddr = lenm1[IDXW-1:0];
				wdata = cur_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	hse_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Working registers, changed by the operation of the current step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
			len_q   <= '0;
			i_q     <= '0;
			pos_q   <= '0;
			top_q   <= '0;
		end else begin
			unique case (ctrl.op)
				OP_LOAD: begin
					if (acc && has_room) begin
						count_q <= count_q + CNTW'(1);
					end else if (acc) begin
						drop_q <= 1'b1;
					end
				end
				OP_BINIT: begin
					len_q <= count_q;
					i_q   <= count_q >> 1;
				end
				OP_BSTEP: begin
					i_q   <= im1;
					pos_q <= im1[IDXW-1:0];
				end
				OP_S1: begin
					top_q <= pos_q;
				end
				OP_S2: begin
					if (rdata > topv_q) begin
						top_q <= left[IDXW-1:0];
					end
				end
				OP_S3: begin
					if (rdata > topv_q) begin
						top_q <= right[IDXW-1:0];
					end
				end
				OP_S5: begin
					pos_q <= top_q;
				end
				OP_ICLR: begin
					i_q <= '0;
				end
				OP_EMIT0, OP_EMIT1: begin
					if (!stall) begin
						i_q <= ip1;
					end
				end
				OP_X3: begin
					len_q <= lenm1;
					pos_q <= '0;
				end
				OP_FIN: begin
					count_q <= '0;
					drop_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Values held while sifting: the moving value and the largest seen so far.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_S1: begin
				cur_q  <= rdata;
				topv_q <= rdata;
			end
			OP_S2, OP_S3: begin
				if (rdata > topv_q) begin
					topv_q <= rdata;
				end
			end
			OP_X1: begin
				cur_q <= rdata;
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded on an emit step, freed when the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && !stall) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !stall) begin
			out_value_q <= rdata;
			out_phase_q <= (ctrl.op == OP_EMIT1);
			out_final_q <= (ctrl.op == OP_EMIT1) && (ip1 == count_q);
			out_ovf_q   <= drop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tlast  = out_final_q;
	assign m_tuser  = {out_ovf_q, out_phase_q};

endmodule

/* hdl/heap_sort_engine.sv */
// Heap sort engine: sorts a set of signed 32-bit values with a binary max-heap.
// Input words arrive on the s_ channel, one value each; s_tlast marks the last
// value of the set and starts the sort. Up to CAPACITY values are kept; later
// values of the same set are dropped, and every result of that set then
// carries the overflow flag.
// Results leave on the m_ channel: first the heap array in array order
// (phase 0), then all values in ascending order (phase 1), with m_tlast on the
// final sorted word. A set of n values gives 2n result words.
// Loading takes one word per cycle. The sort runs in a microcoded sequencer
// over one single-port-read store.
// s_tready stays low from the last word until the sequencer has run its P1 and
// FIN steps after the last result enters the output register. A stall on
// m_tready holds the sequencer at its emit step; nothing is lost. Reset returns
// to loading with an empty store and a clear overflow flag; the store itself
// is not cleared.
module heap_sort_engine #(
	parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic signed [hse_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic signed [hse_pkg::VALUE_W-1:0] m_tdata,  // [31:0] value_res
	output logic                               m_tlast,
	output logic [1:0]                         m_tuser   // [0] phase, [1] overflow
);
	import hse_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	hse_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl  (ctrl)
	);

	hse_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.status  (status),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

/* hdl/hse_checker.sv */
module hse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);

	// A stalled result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word withdrawn while stalled");

	// The final flag appears only on a sorted word.
	a_final_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("final flag on a heap dump word");

	// After the last value of a set the block stops taking input.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken right after the last value");

	// While heap dump words are out, no new input is taken.
	a_no_load_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !s_tready)
		else $error("input ready during heap dump");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (.*);
